>>> rtl/dvt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Distance vector table package
// Shared types, codes and constants for the routing table update block.
// ----------------------------------------------------------------------------
package dvt_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 8;
  localparam int FIELD_W             = 16;
  localparam int INDEX_W             = 3;
  localparam logic [FIELD_W-1:0] COST_UNREACHABLE = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_SET_COST = 2'd1,
    OP_RELAX    = 2'd2,
    OP_READ     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RDWAIT,
    ST_SCAN_SET,
    ST_SCAN_SRC,
    ST_SCAN_CAND,
    ST_FINISH
  } state_t;

  // One table slot as stored in the table memory.
  typedef struct packed {
    logic [FIELD_W-1:0] id;
    logic [FIELD_W-1:0] port;
    logic [FIELD_W-1:0] cost;
    logic [FIELD_W-1:0] hop;
  } row_t;

  // One result transaction.
  typedef struct packed {
    logic [FIELD_W-1:0] id;
    logic [FIELD_W-1:0] hop;
    logic [FIELD_W-1:0] cost;
    logic               valid;
    logic               matched;
    logic               changed;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic load_write;
    logic read_issue;
    logic read_res;
    logic scan_start;
    logic scan_run;
    logic set_eval;
    logic src_eval;
    logic cand_eval;
    logic res_clear;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic idx_ok;
    logic idx_slot_valid;
    logic match_id;
    logic match_src;
    logic cand;
    logic last;
    logic first_seen;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

>>> rtl/dvt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Distance vector table controller
// Sequences decode, table reads, the slot scans and the hand-off of a result.
// ----------------------------------------------------------------------------
module dvt_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire dvt_pkg::status_t st,
  output dvt_pkg::cmd_t         cmd
);

  dvt_pkg::state_t state;
  dvt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dvt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      dvt_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = dvt_pkg::ST_DECODE;
        end
      end
      dvt_pkg::ST_DECODE: begin
        case (st.op)
          dvt_pkg::OP_SET_COST: state_next = dvt_pkg::ST_SCAN_SET;
          dvt_pkg::OP_RELAX:    state_next = dvt_pkg::ST_SCAN_SRC;
          dvt_pkg::OP_READ: begin
            if (st.idx_ok && st.idx_slot_valid) begin
              state_next = dvt_pkg::ST_RDWAIT;
            end else begin
              state_next = dvt_pkg::ST_FINISH;
            end
          end
          default: state_next = dvt_pkg::ST_FINISH;
        endcase
      end
      dvt_pkg::ST_RDWAIT: state_next = dvt_pkg::ST_FINISH;
      dvt_pkg::ST_SCAN_SET: begin
        if (st.match_id || st.last) begin
          state_next = dvt_pkg::ST_FINISH;
        end
      end
      dvt_pkg::ST_SCAN_SRC: begin
        if (st.match_src) begin
          state_next = dvt_pkg::ST_SCAN_CAND;
        end else if (st.last) begin
          state_next = dvt_pkg::ST_FINISH;
        end
      end
      dvt_pkg::ST_SCAN_CAND: begin
        if (st.last) begin
          state_next = dvt_pkg::ST_FINISH;
        end
      end
      dvt_pkg::ST_FINISH: begin
        if (st.out_free) begin
          state_next = dvt_pkg::ST_IDLE;
        end
      end
      default: state_next = dvt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      dvt_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      dvt_pkg::ST_DECODE: begin
        case (st.op)
          dvt_pkg::OP_LOAD: begin
            if (st.idx_ok) begin
              cmd.load_write = 1'b1;
            end else begin
              cmd.res_clear = 1'b1;
            end
          end
          dvt_pkg::OP_READ: begin
            if (st.idx_ok && st.idx_slot_valid) begin
              cmd.read_issue = 1'b1;
            end else begin
              cmd.res_clear = 1'b1;
            end
          end
          default: cmd.scan_start = 1'b1;
        endcase
      end
      dvt_pkg::ST_RDWAIT: cmd.read_res = 1'b1;
      dvt_pkg::ST_SCAN_SET: begin
        cmd.scan_run  = 1'b1;
        cmd.set_eval  = 1'b1;
        cmd.res_clear = st.last && !st.match_id;
      end
      dvt_pkg::ST_SCAN_SRC: begin
        cmd.scan_run   = 1'b1;
        cmd.src_eval   = 1'b1;
        cmd.scan_start = st.match_src;
        cmd.res_clear  = st.last && !st.match_src;
      end
      dvt_pkg::ST_SCAN_CAND: begin
        cmd.scan_run  = 1'b1;
        cmd.cand_eval = 1'b1;
        cmd.res_clear = st.last && !st.first_seen && !st.cand;
      end
      dvt_pkg::ST_FINISH: cmd.out_load = st.out_free;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/dvt_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Distance vector table datapath
// Table memory, valid bits, slot scan pipeline, relaxation adder and the
// result and output registers.
// ----------------------------------------------------------------------------
module dvt_datapath #(
  parameter int TABLE_DEPTH = dvt_pkg::DEFAULT_TABLE_DEPTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [dvt_pkg::FIELD_W-1:0] cfg_wdata,
  input  wire logic [1:0]                  operation,
  input  wire logic [dvt_pkg::INDEX_W-1:0] entry_index,
  input  wire logic [dvt_pkg::FIELD_W-1:0] dest_id,
  input  wire logic [dvt_pkg::FIELD_W-1:0] dest_port,
  input  wire logic [dvt_pkg::FIELD_W-1:0] cost,
  input  wire logic [dvt_pkg::FIELD_W-1:0] source_port,
  input  wire logic                        out_stall,
  output logic                             out_valid,
  output logic [dvt_pkg::FIELD_W-1:0]      entry_dest_id,
  output logic [dvt_pkg::FIELD_W-1:0]      entry_next_hop,
  output logic [dvt_pkg::FIELD_W-1:0]      entry_cost,
  output logic                             entry_valid,
  output logic                             matched,
  output logic                             changed,
  input  wire dvt_pkg::cmd_t               cmd,
  output dvt_pkg::status_t                 st
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = IDX_W + 1;
  localparam int CMP_W = (CNT_W > dvt_pkg::INDEX_W) ? CNT_W : dvt_pkg::INDEX_W;
  localparam int FW    = dvt_pkg::FIELD_W;

  // Captured transaction and configuration.
  logic [FW-1:0]               self_id;
  dvt_pkg::op_t                cur_op;
  logic [dvt_pkg::INDEX_W-1:0] cur_index;
  logic [FW-1:0]               cur_dest_id;
  logic [FW-1:0]               cur_dest_port;
  logic [FW-1:0]               cur_cost;
  logic [FW-1:0]               cur_source_port;

  // Table storage.
  dvt_pkg::row_t             mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]    slot_valid;
  dvt_pkg::row_t             rd_row;

  // Scan pipeline and relaxation state.
  logic [CNT_W-1:0]          scan_cnt;
  logic                      eval_vld;
  logic [IDX_W-1:0]          eval_idx;
  logic                      first_seen;
  logic [FW-1:0]             src_base;
  logic [FW-1:0]             src_hop;

  dvt_pkg::result_t          res;
  dvt_pkg::result_t          out_res;

  logic [CMP_W-1:0]          idx_ext;
  logic [IDX_W-1:0]          idx_addr;
  logic                      idx_ok;
  logic                      scan_more;
  logic                      rd_en;
  logic [IDX_W-1:0]          rd_addr;
  logic                      wr_en;
  logic [IDX_W-1:0]          wr_addr;
  dvt_pkg::row_t             wr_row;
  logic                      load_wr;
  logic                      set_wr;
  logic                      relax_wr;
  logic [FW-1:0]             load_hop;
  logic [FW:0]               relax_sum;
  logic                      better;
  logic                      eval_slot_valid;
  logic                      match_id;
  logic                      match_src;
  logic                      cand;

  assign idx_ext   = CMP_W'(cur_index);
  assign idx_addr  = idx_ext[IDX_W-1:0];
  assign idx_ok    = idx_ext < CMP_W'(TABLE_DEPTH);
  assign scan_more = scan_cnt < CNT_W'(TABLE_DEPTH);

  assign load_hop = (cur_cost == dvt_pkg::COST_UNREACHABLE) ? dvt_pkg::COST_UNREACHABLE :
                    (cur_cost == '0) ? self_id : cur_dest_id;

  // Compared one bit wider so a large base plus cost never wraps.
  assign relax_sum = {1'b0, src_base} + {1'b0, cur_cost};
  assign better    = relax_sum < {1'b0, rd_row.cost};

  assign eval_slot_valid = eval_vld && slot_valid[eval_idx];
  assign match_id  = eval_slot_valid && (rd_row.id == cur_dest_id);
  assign match_src = eval_slot_valid && (rd_row.port == cur_source_port);
  assign cand      = eval_slot_valid && (rd_row.id != self_id) &&
                     (rd_row.port != cur_source_port) && (rd_row.port == cur_dest_port);

  assign load_wr  = cmd.load_write;
  assign set_wr   = cmd.set_eval && match_id;
  assign relax_wr = cmd.cand_eval && cand && better;

  always_comb begin
    wr_en   = load_wr || set_wr || relax_wr;
    wr_addr = load_wr ? idx_addr : eval_idx;
    wr_row  = rd_row;
    if (load_wr) begin
      wr_row.id   = cur_dest_id;
      wr_row.port = cur_dest_port;
      wr_row.cost = cur_cost;
      wr_row.hop  = load_hop;
    end else if (set_wr) begin
      wr_row.cost = cur_cost;
    end else begin
      wr_row.cost = relax_sum[FW-1:0];
      wr_row.hop  = src_hop;
    end
  end

  always_comb begin
    rd_en   = cmd.read_issue || (cmd.scan_run && scan_more);
    rd_addr = cmd.read_issue ? idx_addr : scan_cnt[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_row <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      self_id <= '0;
    end else if (cfg_we) begin
      self_id <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_op          <= dvt_pkg::op_t'(operation);
      cur_index       <= entry_index;
      cur_dest_id     <= dest_id;
      cur_dest_port   <= dest_port;
      cur_cost        <= cost;
      cur_source_port <= source_port;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (load_wr) begin
      slot_valid[idx_addr] <= 1'b1;
    end
  end

  // The scan issues one slot read per cycle and evaluates each slot in the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt   <= '0;
      eval_vld   <= 1'b0;
      eval_idx   <= '0;
      first_seen <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_cnt   <= '0;
      eval_vld   <= 1'b0;
      first_seen <= 1'b0;
    end else if (cmd.scan_run) begin
      eval_vld <= scan_more;
      if (scan_more) begin
        scan_cnt <= scan_cnt + CNT_W'(1);
        eval_idx <= scan_cnt[IDX_W-1:0];
      end
      if (cmd.cand_eval && cand) begin
        first_seen <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.src_eval && match_src) begin
      src_base <= rd_row.cost;
      src_hop  <= rd_row.id;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_clear) begin
      res <= '0;
    end else if (load_wr) begin
      res <= '{id: cur_dest_id, hop: load_hop, cost: cur_cost,
               valid: 1'b1, matched: 1'b1, changed: 1'b1};
    end else if (cmd.read_res) begin
      res <= '{id: rd_row.id, hop: rd_row.hop, cost: rd_row.cost,
               valid: 1'b1, matched: 1'b1, changed: 1'b0};
    end else if (set_wr) begin
      res <= '{id: rd_row.id, hop: rd_row.hop, cost: cur_cost,
               valid: 1'b1, matched: 1'b1, changed: (rd_row.cost != cur_cost)};
    end else if (cmd.cand_eval && cand) begin
      if (!first_seen) begin
        res <= '{id: rd_row.id,
                 hop: better ? src_hop : rd_row.hop,
                 cost: better ? relax_sum[FW-1:0] : rd_row.cost,
                 valid: 1'b1, matched: 1'b1, changed: better};
      end else begin
        res.changed <= res.changed | better;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_res <= res;
    end
  end

  assign entry_dest_id  = out_res.id;
  assign entry_next_hop = out_res.hop;
  assign entry_cost     = out_res.cost;
  assign entry_valid    = out_res.valid;
  assign matched        = out_res.matched;
  assign changed        = out_res.changed;

  always_comb begin
    st.op             = cur_op;
    st.idx_ok         = idx_ok;
    st.idx_slot_valid = slot_valid[idx_addr];
    st.match_id       = match_id;
    st.match_src      = match_src;
    st.cand           = cand;
    st.last           = eval_vld && (eval_idx == IDX_W'(TABLE_DEPTH - 1));
    st.first_seen     = first_seen;
    st.out_free       = !out_valid || !out_stall;
  end

`ifndef ASSERT_OFF
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("result register loaded while a result is stalled");

  a_single_table_write: assert property (@(posedge clk) disable iff (rst)
    $onehot0({load_wr, set_wr, relax_wr}))
    else $error("more than one table write in a cycle");

  a_unmatched_is_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !matched) |-> (!entry_valid && !changed && entry_cost == '0 &&
                                 entry_dest_id == '0 && entry_next_hop == '0))
    else $error("unmatched result carries nonzero fields");

  a_scan_restart_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_start |=> !eval_vld && !first_seen)
    else $error("scan restart left stale evaluation state");
`endif

endmodule
`default_nettype wire

>>> rtl/distance_vector_table_update_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Distance vector table update
// Routing table with load, set link cost, Bellman-Ford relax and read.
// ----------------------------------------------------------------------------
// Usage notes:
// Each input transaction (operation plus its fields) is accepted when in_valid
// is high and in_stall is low, and produces exactly one result transaction on
// the output channel, accepted when out_valid is high and out_stall is low.
// The self router id is written through cfg_we and cfg_wdata; the user must do
// so only while the block is idle, as the block itself does not enforce this.
// The table memory yields one slot per cycle to the scan; relax scans once for
// the source slot and, if it finds one, once more for the candidates.
// A finished result waits in an output register, so the next transaction is
// accepted while the previous result is still stalled; the block holds
// in_stall high only while it works on one transaction, or when a second
// result is ready and the first has not yet been taken.
// Synchronous reset clears all slot valid bits, the self router id, the
// output valid and the controller state; table contents are not cleared and
// are never reported for a slot that is not valid.
// ----------------------------------------------------------------------------
module distance_vector_table_update_top #(
  parameter int TABLE_DEPTH = dvt_pkg::DEFAULT_TABLE_DEPTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [dvt_pkg::FIELD_W-1:0] cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  operation,
  input  wire logic [dvt_pkg::INDEX_W-1:0] entry_index,
  input  wire logic [dvt_pkg::FIELD_W-1:0] dest_id,
  input  wire logic [dvt_pkg::FIELD_W-1:0] dest_port,
  input  wire logic [dvt_pkg::FIELD_W-1:0] cost,
  input  wire logic [dvt_pkg::FIELD_W-1:0] source_port,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [dvt_pkg::FIELD_W-1:0]      entry_dest_id,
  output logic [dvt_pkg::FIELD_W-1:0]      entry_next_hop,
  output logic [dvt_pkg::FIELD_W-1:0]      entry_cost,
  output logic                             entry_valid,
  output logic                             matched,
  output logic                             changed
);

  // Commands flow from the controller to the datapath, status flows back.
  dvt_pkg::cmd_t    cmd;
  dvt_pkg::status_t st;

  dvt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  dvt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .operation      (operation),
    .entry_index    (entry_index),
    .dest_id        (dest_id),
    .dest_port      (dest_port),
    .cost           (cost),
    .source_port    (source_port),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .entry_dest_id  (entry_dest_id),
    .entry_next_hop (entry_next_hop),
    .entry_cost     (entry_cost),
    .entry_valid    (entry_valid),
    .matched        (matched),
    .changed        (changed),
    .cmd            (cmd),
    .st             (st)
  );

endmodule
`default_nettype wire
